@@ design/sfbc_pkg.sv @@
// shared types, constants and arithmetic helpers for the stereo compressor
`default_nettype none
package sfbc_pkg;
    localparam int SMP_W   = 24;
    localparam int ST_W    = 32;
    localparam int RATE_W  = 22;
    localparam int G_W     = 28;
    localparam int Y_W     = 40;
    localparam int CNT_W   = 6;
    localparam int R_STEPS = 22;
    localparam int Q_STEPS = 33;
    localparam int ADDR_W  = 5;

    localparam logic [ST_W-1:0] ST_MAX = '1;
    localparam logic [ST_W-1:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [ST_W-1:0] ONE_Q26 = 32'h0400_0000;

    typedef enum logic [2:0] {
        REG_INPUT_GAIN = 3'd0,
        REG_COMP_RATE  = 3'd1,
        REG_OUT_RECIP  = 3'd2,
        REG_OUT_LEVEL  = 3'd3,
        REG_WET_MIX    = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        LN_IDLE, LN_GAIN, LN_RDIV, LN_OSQ, LN_TGT, LN_SQ, LN_QDIV,
        LN_CTL, LN_MIX, LN_Y1, LN_Y2, LN_Y3, LN_Y4, LN_DONE
    } t_lane_st;

    typedef struct packed {
        logic [15:0]       input_gain;
        logic [RATE_W-1:0] comp_rate;
        logic [16:0]       output_gain_recip;
        logic [15:0]       output_level;
        logic [15:0]       wet_mix;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic ack;
        logic phase;
    } t_lane_cmd;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_sts;

    // s + floor((u - s) * r / 2^32), equal to the weighted blend of s and u
    function automatic logic [ST_W-1:0] smooth(input logic [ST_W-1:0] s,
                                               input logic [ST_W-1:0] u,
                                               input logic [RATE_W-1:0] r);
        logic signed [32:0] diff;
        logic signed [55:0] p;
        logic signed [32:0] v;
        diff = $signed({1'b0, u}) - $signed({1'b0, s});
        p = diff * $signed({1'b0, r});
        v = $signed({1'b0, s}) + 33'(p >>> 32);
        return v[ST_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [57:0] v);
        if (v > 58'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -58'sd8388608) begin
            return 24'sh800000;
        end
        return v[SMP_W-1:0];
    endfunction
endpackage
`default_nettype wire

@@ design/sfbc_if.sv @@
// valid/ready channels for input frames and output frames
`default_nettype none
interface sfbc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfbc_pkg::SMP_W-1:0]   left_sample;
    logic signed [sfbc_pkg::SMP_W-1:0]   right_sample;
    modport source (output valid, left_sample, right_sample, input ready);
    modport sink (input valid, left_sample, right_sample, output ready);
endinterface

interface sfbc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [sfbc_pkg::SMP_W-1:0]   left_out;
    logic signed [sfbc_pkg::SMP_W-1:0]   right_out;
    modport source (output valid, left_out, right_out, input ready);
    modport sink (input valid, left_out, right_out, output ready);
endinterface
`default_nettype wire

@@ design/sfbc_cfg.sv @@
// apb configuration register file
`default_nettype none
module sfbc_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [sfbc_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                 i_pwdata,
    output logic [31:0]                      o_prdata,
    output logic                             o_pready,
    output sfbc_pkg::t_cfg                   o_cfg
);
    import sfbc_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   idx;
    logic       wr;

    assign idx = t_reg_idx'(i_paddr[ADDR_W-1:2]);
    assign wr = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_gain        <= 16'd8192;
            r_cfg.comp_rate         <= '0;
            r_cfg.output_gain_recip <= 17'd65536;
            r_cfg.output_level      <= 16'd16384;
            r_cfg.wet_mix           <= 16'd32768;
        end else if (wr) begin
            unique case (idx)
                REG_INPUT_GAIN: r_cfg.input_gain <= i_pwdata[15:0];
                REG_COMP_RATE:  r_cfg.comp_rate <= i_pwdata[RATE_W-1:0];
                REG_OUT_RECIP:  r_cfg.output_gain_recip <= i_pwdata[16:0];
                REG_OUT_LEVEL:  r_cfg.output_level <= i_pwdata[15:0];
                REG_WET_MIX:    r_cfg.wet_mix <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INPUT_GAIN: o_prdata = {16'd0, r_cfg.input_gain};
            REG_COMP_RATE:  o_prdata = {10'd0, r_cfg.comp_rate};
            REG_OUT_RECIP:  o_prdata = {15'd0, r_cfg.output_gain_recip};
            REG_OUT_LEVEL:  o_prdata = {16'd0, r_cfg.output_level};
            REG_WET_MIX:    o_prdata = {16'd0, r_cfg.wet_mix};
            default:        o_prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ design/sfbc_lane.sv @@
// one channel of the compressor: sequencer with rate and reciprocal dividers
`default_nettype none
module sfbc_lane (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire sfbc_pkg::t_lane_cmd               i_cmd,
    input  wire sfbc_pkg::t_cfg                    i_cfg,
    input  wire logic signed [sfbc_pkg::SMP_W-1:0] i_smp,
    output sfbc_pkg::t_lane_sts                    o_sts,
    output logic signed [sfbc_pkg::SMP_W-1:0]      o_y
);
    import sfbc_pkg::*;

    t_lane_st                r_st, n_st;
    logic signed [SMP_W-1:0] r_x;
    logic                    r_ph;
    logic signed [G_W-1:0]   r_g;
    logic [24:0]             r_dv;
    logic [24:0]             r_rrem;
    logic [RATE_W-1:0]       r_r;
    logic [CNT_W-1:0]        r_cnt;
    logic [ST_W-1:0]         r_osq_p, r_osq_n;
    logic [24:0]             r_wp, r_wn;
    logic [ST_W-1:0]         r_tp, r_tn;
    logic [49:0]             r_sq;
    logic [49:0]             r_qrem;
    logic [32:0]             r_q;
    logic [ST_W-1:0]         r_cpos [2];
    logic [ST_W-1:0]         r_cneg [2];
    logic [33:0]             r_m;
    logic signed [Y_W-1:0]   r_y;
    logic signed [SMP_W-1:0] r_last;

    logic signed [40:0] gain_p;
    logic [24:0]        last_mag;
    logic [25:0]        rt;
    logic signed [28:0] ip, in;
    logic [26:0]        op, on;
    logic [53:0]        osq_p, osq_n;
    logic [ST_W-1:0]    tsel;
    logic [63:0]        tsq;
    logic [50:0]        qt;
    logic [ST_W-1:0]    calc;
    logic [57:0]        mix;
    logic signed [62:0] y1;
    logic signed [57:0] y2;
    logic signed [56:0] y3;
    logic [15:0]        wet, dry;
    logic signed [57:0] y4;
    logic               gpos;

    always_comb begin
        gain_p = r_x * $signed({1'b0, i_cfg.input_gain});
        last_mag = r_last[SMP_W-1] ? (25'd0 - {r_last[SMP_W-1], r_last}) : {1'b0, r_last};
        rt = {r_rrem, 1'b0};
        ip = 29'(r_g) + 29'sd8388608;
        in = 29'sd8388608 - 29'(r_g);
        op = ip[28] ? '0 : ip[26:0];
        on = in[28] ? '0 : in[26:0];
        osq_p = op * op;
        osq_n = on * on;
        gpos = (r_g > 0);
        tsel = gpos ? r_tp : r_tn;
        tsq = tsel * tsel;
        qt = {r_qrem, 1'b0};
        calc = r_q[32] ? ST_MAX : r_q[ST_W-1:0];
        mix = 58'(r_cpos[r_ph] * r_wp) + 58'(r_cneg[r_ph] * r_wn);
        y1 = r_g * $signed({1'b0, r_m});
        y2 = r_y * $signed({1'b0, i_cfg.output_gain_recip});
        y3 = r_y * $signed({1'b0, i_cfg.output_level});
        wet = (i_cfg.wet_mix > 16'd32768) ? 16'd32768 : i_cfg.wet_mix;
        dry = 16'd32768 - wet;
        y4 = 58'(r_y * $signed({1'b0, wet})) + 58'(r_x * $signed({1'b0, dry}));
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            LN_IDLE: if (i_cmd.start) n_st = LN_GAIN;
            LN_GAIN: n_st = LN_RDIV;
            LN_RDIV: if (r_cnt == CNT_W'(R_STEPS - 1)) n_st = LN_OSQ;
            LN_OSQ:  n_st = LN_TGT;
            LN_TGT:  n_st = LN_SQ;
            LN_SQ:   n_st = LN_QDIV;
            LN_QDIV: begin
                if (r_sq < 50'h4000_0000 || r_cnt == CNT_W'(Q_STEPS - 1)) n_st = LN_CTL;
            end
            LN_CTL:  n_st = LN_MIX;
            LN_MIX:  n_st = LN_Y1;
            LN_Y1:   n_st = LN_Y2;
            LN_Y2:   n_st = LN_Y3;
            LN_Y3:   n_st = LN_Y4;
            LN_Y4:   n_st = LN_DONE;
            LN_DONE: if (i_cmd.ack) n_st = LN_IDLE;
            default: n_st = LN_IDLE;
        endcase
    end

    always_comb begin
        o_sts.idle = (r_st == LN_IDLE);
        o_sts.done = (r_st == LN_DONE);
        o_y = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= LN_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= ONE_Q26;
            r_tn <= ONE_Q26;
            r_cpos[0] <= ONE_Q24;
            r_cpos[1] <= ONE_Q24;
            r_cneg[0] <= ONE_Q24;
            r_cneg[1] <= ONE_Q24;
            r_last <= '0;
        end else begin
            case (r_st)
                LN_TGT: begin
                    r_tp <= smooth(r_tp, r_osq_p, r_r);
                    r_tn <= smooth(r_tn, r_osq_n, r_r);
                end
                LN_CTL: begin
                    if (gpos) begin
                        r_cpos[r_ph] <= smooth(r_cpos[r_ph], calc, r_r);
                    end else begin
                        r_cneg[r_ph] <= smooth(r_cneg[r_ph], calc, r_r);
                    end
                end
                LN_Y4: r_last <= sat_smp(y4 >>> 15);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            LN_IDLE: begin
                r_x <= i_smp;
                r_ph <= i_cmd.phase;
            end
            LN_GAIN: begin
                r_g <= gain_p[40:13];
                r_rrem <= {2'b0, i_cfg.comp_rate, 1'b0};
                r_dv <= 25'h80_0000 + last_mag;
                r_r <= '0;
                r_cnt <= '0;
            end
            LN_RDIV: begin
                if (rt >= {1'b0, r_dv}) begin
                    r_rrem <= 25'(rt - {1'b0, r_dv});
                    r_r <= {r_r[RATE_W-2:0], 1'b1};
                end else begin
                    r_rrem <= rt[24:0];
                    r_r <= {r_r[RATE_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            LN_OSQ: begin
                r_osq_p <= (osq_p[53:52] != 2'b00) ? ST_MAX : osq_p[51:20];
                r_osq_n <= (osq_n[53:52] != 2'b00) ? ST_MAX : osq_n[51:20];
                r_wp <= (op > 27'h100_0000) ? 25'h100_0000 : op[24:0];
                r_wn <= (on > 27'h100_0000) ? 25'h100_0000 : on[24:0];
            end
            LN_SQ: begin
                r_sq <= tsq[63:14];
                r_qrem <= 50'h2000_0000;
                r_q <= '0;
                r_cnt <= '0;
            end
            LN_QDIV: begin
                if (r_sq < 50'h4000_0000) begin
                    r_q <= 33'h1_0000_0000;
                end else if (qt >= {1'b0, r_sq}) begin
                    r_qrem <= 50'(qt - {1'b0, r_sq});
                    r_q <= {r_q[31:0], 1'b1};
                end else begin
                    r_qrem <= qt[49:0];
                    r_q <= {r_q[31:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            LN_MIX: r_m <= mix[57:24];
            LN_Y1:  r_y <= Y_W'(y1 >>> 24);
            LN_Y2:  r_y <= Y_W'(y2 >>> 16);
            LN_Y3:  r_y <= Y_W'(y3 >>> 14);
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ design/stereo_flip_bipolar_compressor.sv @@
// top level: two channel lanes, apb registers and the merged output register
//  channel | dir | handshake       | payload
//  i_in    | in  | valid / ready   | left_sample, right_sample
//  o_out   | out | valid / ready   | left_out, right_out
//  apb     | in  | psel / penable  | paddr, pwdata, prdata
// from accept to result each lane runs a rate divider and then the 33-step
// reciprocal divider, which is skipped when the control saturates
// the next item is taken once both lanes are idle, even while a result waits
// synchronous active-low reset restores targets, controls and registers
`default_nettype none
module stereo_flip_bipolar_compressor (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    sfbc_in_if.sink                          i_in,
    sfbc_out_if.source                       o_out,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [sfbc_pkg::ADDR_W-1:0] i_paddr,
    input  wire logic [31:0]                 i_pwdata,
    output logic [31:0]                      o_prdata,
    output logic                             o_pready
);
    import sfbc_pkg::*;

    t_cfg                    cfg;
    t_lane_cmd               cmd;
    t_lane_sts               sts_l, sts_r;
    logic signed [SMP_W-1:0] y_l, y_r;
    logic                    load;
    logic                    r_ov, n_ov;
    logic                    r_phase;
    logic signed [SMP_W-1:0] r_lo, r_ro;

    sfbc_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_psel(i_psel), .i_penable(i_penable),
        .i_pwrite(i_pwrite), .i_paddr(i_paddr), .i_pwdata(i_pwdata),
        .o_prdata(o_prdata), .o_pready(o_pready), .o_cfg(cfg)
    );

    sfbc_lane u_lane_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cfg(cfg),
        .i_smp(i_in.left_sample), .o_sts(sts_l), .o_y(y_l)
    );

    sfbc_lane u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cfg(cfg),
        .i_smp(i_in.right_sample), .o_sts(sts_r), .o_y(y_r)
    );

    assign i_in.ready = sts_l.idle && sts_r.idle;
    assign load = sts_l.done && sts_r.done && (!r_ov || o_out.ready);
    assign n_ov = load || (r_ov && !o_out.ready);

    always_comb begin
        cmd.start = i_in.valid && i_in.ready;
        cmd.ack = load;
        cmd.phase = r_phase;
    end

    assign o_out.valid = r_ov;
    assign o_out.left_out = r_lo;
    assign o_out.right_out = r_ro;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_ov <= n_ov;
            if (load) r_phase <= !r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_lo <= y_l;
            r_ro <= y_r;
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (!sts_l.idle && !sts_r.idle))
        else $error("lanes did not start on an accepted item");

    a_phase_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_phase != $past(r_phase)))
        else $error("flip phase did not toggle on a result");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (o_out.valid && o_out.left_out == $past(y_l)))
        else $error("merged result not presented");
endmodule
`default_nettype wire

@@ sim/stereo_flip_bipolar_compressor_test.sv @@
// testbench for the stereo flip-phase compressor: directed and random frames against a predictor
`timescale 1ns / 1ps
`default_nettype none
module stereo_flip_bipolar_compressor_test;
    import sfbc_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd5;
    localparam longint unsigned SAT32 = 64'hFFFF_FFFF;

    typedef struct packed {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
    } t_frame;

    logic i_clk;
    logic i_rst_n;
    logic i_psel;
    logic i_penable;
    logic i_pwrite;
    logic [ADDR_W-1:0] i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic o_pready;

    sfbc_in_if in_ch();
    sfbc_out_if out_ch();

    stereo_flip_bipolar_compressor dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source),
        .i_psel(i_psel),
        .i_penable(i_penable),
        .i_pwrite(i_pwrite),
        .i_paddr(i_paddr),
        .i_pwdata(i_pwdata),
        .o_prdata(o_prdata),
        .o_pready(o_pready)
    );

    // predictor state and register copies
    longint unsigned tgt_pos[2];
    longint unsigned tgt_neg[2];
    longint unsigned ctl_q24[8];
    longint last_y[2];
    bit flip;
    longint unsigned gain_in, rate_num, recip_out, level_out, wet_share;

    t_frame expected_frames[$];
    int err_cnt;
    int hold_len;
    bit rst_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint unsigned blend(longint unsigned s, longint unsigned u,
                                              longint unsigned r);
        longint unsigned v;
        v = (s * ((64'd1 << 32) - r) + u * r) >> 32;
        return v > SAT32 ? SAT32 : v;
    endfunction

    function automatic longint unsigned offset_square(longint off);
        longint unsigned sq;
        if (off < 0) begin
            return 0;
        end
        sq = (longint'(off) * longint'(off)) >> 20;
        return sq > SAT32 ? SAT32 : sq;
    endfunction

    function automatic longint unsigned inv_square(longint unsigned t);
        longint unsigned sq;
        longint unsigned q;
        sq = (t * t) >> 14;
        if (sq == 0) begin
            return SAT32;
        end
        q = (64'd1 << 62) / sq;
        return q > SAT32 ? SAT32 : q;
    endfunction

    function automatic longint compress_channel(int ch, longint x);
        longint g, ip, ineg, y, dry;
        longint unsigned mag, r, wp, wn, cp, cn, m, wet;
        int base;
        g = (x * longint'(gain_in)) >>> 13;
        mag = last_y[ch] < 0 ? -last_y[ch] : last_y[ch];
        r = (rate_num << 23) / ((64'd1 << 23) + mag);
        ip = g + (64'sd1 <<< 23);
        ineg = (64'sd1 <<< 23) - g;
        base = ch * 4 + (flip ? 2 : 0);
        if (ip < 0) ip = 0;
        if (ineg < 0) ineg = 0;
        wp = ip > (64'sd1 <<< 24) ? (64'd1 << 24) : ip;
        wn = ineg > (64'sd1 <<< 24) ? (64'd1 << 24) : ineg;
        tgt_pos[ch] = blend(tgt_pos[ch], offset_square(ip), r);
        tgt_neg[ch] = blend(tgt_neg[ch], offset_square(ineg), r);
        cp = inv_square(tgt_pos[ch]);
        cn = inv_square(tgt_neg[ch]);
        if (g > 0) begin
            ctl_q24[base] = blend(ctl_q24[base], cp, r);
        end else begin
            ctl_q24[base + 1] = blend(ctl_q24[base + 1], cn, r);
        end
        m = (ctl_q24[base] * wp + ctl_q24[base + 1] * wn) >> 24;
        y = (g * longint'(m)) >>> 24;
        y = (y * longint'(recip_out)) >>> 16;
        y = (y * longint'(level_out)) >>> 14;
        wet = wet_share > 32768 ? 32768 : wet_share;
        dry = x * longint'(32768 - wet);
        y = (y * longint'(wet) + dry) >>> 15;
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        last_y[ch] = y;
        return y;
    endfunction

    function automatic t_frame compress_frame(logic signed [SMP_W-1:0] l,
                                              logic signed [SMP_W-1:0] r);
        t_frame f;
        f.left = SMP_W'(compress_channel(0, longint'(l)));
        f.right = SMP_W'(compress_channel(1, longint'(r)));
        flip = ~flip;
        return f;
    endfunction

    typedef logic [2:0] t_reg_idx_wide;

    task automatic apb_write(t_reg_idx_wide idx, logic [31:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        case (idx)
            REG_INPUT_GAIN: gain_in = value[15:0];
            REG_COMP_RATE:  rate_num = value[RATE_W-1:0];
            REG_OUT_RECIP:  recip_out = value[16:0];
            REG_OUT_LEVEL:  level_out = value[15:0];
            REG_WET_MIX:    wet_share = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        wait (expected_frames.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] ig, logic [31:0] cr, logic [31:0] rc,
                              logic [31:0] lv, logic [31:0] wm);
        drain();
        apb_write(REG_INPUT_GAIN, ig);
        apb_write(REG_COMP_RATE, cr);
        apb_write(REG_OUT_RECIP, rc);
        apb_write(REG_OUT_LEVEL, lv);
        apb_write(REG_WET_MIX, wm);
    endtask

    task automatic send_frame(logic signed [SMP_W-1:0] l, logic signed [SMP_W-1:0] r,
                              int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.left_sample <= l;
        in_ch.right_sample <= r;
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
        end
        expected_frames.push_back(compress_frame(l, r));
        @(posedge i_clk);
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return SMP_W'($urandom_range(0, 255) - 128);
            default: return SMP_W'($urandom);
        endcase
    endfunction

    // result checker
    initial begin
        t_frame got, want;
        int stall;
        wait (rst_done);
        forever begin
            if (hold_len > 0) begin
                stall = hold_len;
                hold_len = 0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            forever begin
                @(negedge i_clk);
                if (out_ch.valid) break;
            end
            got.left = out_ch.left_out;
            got.right = out_ch.right_out;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected item left=%0d right=%0d", $time, got.left,
                         got.right);
                err_cnt++;
            end else begin
                want = expected_frames.pop_front();
                if (got.left !== want.left) begin
                    $display("%0t: left mismatch expected=%0d actual=%0d", $time,
                             want.left, got.left);
                    err_cnt++;
                end
                if (got.right !== want.right) begin
                    $display("%0t: right mismatch expected=%0d actual=%0d", $time,
                             want.right, got.right);
                    err_cnt++;
                end
            end
            @(posedge i_clk);
        end
    end

    task automatic test_defaults();
        send_frame(24'h7FFFFF, 24'h800000, draw_gap());
        send_frame(24'h000000, 24'h000000, draw_gap());
        send_frame(24'h800000, 24'h7FFFFF, draw_gap());
        send_frame(24'hFFFFFF, 24'h000001, draw_gap());
        send_frame(24'h400000, 24'hC00000, draw_gap());
    endtask

    task automatic test_extreme_settings();
        // fast tracking, input gain 41059, output reciprocal 21845
        set_config(41059, 4194303, 21845, 32768, 32768);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_frame(24'h7FFFFF, 24'h7FFFFF, 0);
        send_frame(24'h800000, 24'h800000, 0);
        send_frame(24'h000000, 24'hFFFFFF, 0);
        send_frame(24'h7FFFFF, 24'h800000, 0);
        send_frame(24'h000001, 24'h000000, 0);
        // register bits beyond the ranges, wet above one
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
        send_frame(24'h7FFFFF, 24'h800000, 0);
        send_frame(24'h123456, 24'hEDCBA9, 0);
        send_frame(24'h000000, 24'h000000, 0);
        // all dry, zero level, slowest rate
        set_config(8192, 0, 65536, 0, 0);
        send_frame(24'h7FFFFF, 24'h800000, 0);
        send_frame(24'h555555, 24'hAAAAAA, 0);
        set_config(0, 1, 0, 1, 16384);
        send_frame(24'h7FFFFF, 24'h800000, 0);
        send_frame(24'h000001, 24'hFFFFFF, 0);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            set_config(ph == 0 ? 41059 : $urandom_range(0, 65535),
                       ph < 4 ? $urandom_range(3000000, 4194303) : $urandom,
                       ph == 1 ? 21845 : $urandom_range(0, 131071),
                       ph == 2 ? 32768 : $urandom_range(0, 65535),
                       ph == 3 ? 0 : $urandom_range(0, 65535));
            for (int k = 0; k < 280; k++) begin
                send_frame(rand_sample(), rand_sample(), draw_gap());
            end
        end
    endtask

    task automatic test_backpressure();
        hold_len = 400;
        for (int k = 0; k < 20; k++) begin
            send_frame(rand_sample(), rand_sample(), 0);
        end
        drain();
        for (int k = 0; k < 20; k++) begin
            send_frame(rand_sample(), rand_sample(), draw_gap());
        end
    endtask

    initial begin
        err_cnt = 0;
        hold_len = 0;
        rst_done = 1'b0;
        for (int c = 0; c < 2; c++) begin
            tgt_pos[c] = 64'd1 << 26;
            tgt_neg[c] = 64'd1 << 26;
            last_y[c] = 0;
        end
        for (int e = 0; e < 8; e++) ctl_q24[e] = 64'd1 << 24;
        flip = 1'b0;
        gain_in = 8192;
        rate_num = 0;
        recip_out = 65536;
        level_out = 16384;
        wet_share = 32768;
        i_rst_n = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.left_sample = '0;
        in_ch.right_sample = '0;
        out_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        test_defaults();
        test_extreme_settings();
        test_backpressure();
        test_random_phases();

        in_ch.valid <= 1'b0;
        wait (expected_frames.size() == 0);
        repeat (100) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
